FILE: sv/gossip_membership_views_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gossip membership block
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GOSSIP_MEMBERSHIP_VIEWS_MACROS_SVH
`define GOSSIP_MEMBERSHIP_VIEWS_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GMV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define GMV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gmv_pkg.sv
// ----------------------------------------------------------------------------
// Gossip membership package
// Operation and message codes, command and status types, random step.
// ----------------------------------------------------------------------------
package gmv_pkg;

  localparam logic [2:0] OP_JOIN  = 3'd0;
  localparam logic [2:0] OP_FWD   = 3'd1;
  localparam logic [2:0] OP_DISC  = 3'd2;
  localparam logic [2:0] OP_SHUF  = 3'd3;
  localparam logic [2:0] OP_REPLY = 3'd4;
  localparam logic [2:0] OP_TICK  = 3'd5;

  localparam logic [1:0] MK_FJ    = 2'd0;
  localparam logic [1:0] MK_DISC  = 2'd1;
  localparam logic [1:0] MK_SHUF  = 2'd2;
  localparam logic [1:0] MK_REPLY = 2'd3;

  localparam logic [1:0] CFG_SELF   = 2'd0;
  localparam logic [1:0] CFG_PERIOD = 2'd1;
  localparam logic [1:0] CFG_SEED   = 2'd2;

  localparam logic [7:0]  ACTIVE_WALK   = 8'd6;
  localparam logic [7:0]  PASSIVE_WALK  = 8'd3;
  localparam logic [31:0] SEED_FALLBACK = 32'h12345678;
  localparam logic [31:0] PERIOD_RESET  = 32'd10000;
  localparam int XS_A = 13;
  localparam int XS_B = 17;
  localparam int XS_C = 5;

  typedef enum logic {MEM_A = 1'b0, MEM_P = 1'b1} mem_e;

  typedef enum logic [1:0] {
    KEY_ORIGIN = 2'd0, KEY_ENTRY = 2'd1, KEY_SENDER = 2'd2, KEY_TMP = 2'd3
  } key_e;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0, IDX_CLR = 3'd1, IDX_INC = 3'd2, IDX_WRAP = 3'd3, IDX_DRAW = 3'd4
  } idx_e;

  typedef enum logic [1:0] {CNT_HOLD = 2'd0, CNT_CLR = 2'd1, CNT_INC = 2'd2} cnt_e;

  typedef enum logic [2:0] {
    EM_DISC = 3'd0, EM_FJ6 = 3'd1, EM_FJT = 3'd2, EM_SMP = 3'd3, EM_SELF = 3'd4
  } emit_e;

  typedef struct packed {
    logic  load_item;
    logic  key_ld;
    key_e  key_sel;
    idx_e  idx_op;
    cnt_e  cnt_op;
    logic  draw_go;
    logic  rd;
    logic  rd_last;
    logic  wr;
    logic  wr_at_used;
    logic  wr_key;
    logic  use_inc;
    logic  use_dec;
    logic  tmp_ld;
    logic  lst_ld;
    logic  emit;
    emit_e emit_sel;
    logic  flush;
    mem_e  mem;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic origin_self;
    logic entry_self;
    logic evalid;
    logic elast;
    logic ttl_zero;
    logic ttl_pw;
    logic a_full;
    logic a_le1;
    logic a_empty;
    logic p_empty;
    logic p_full;
    logic period_hit;
    logic a_end;
    logic p_end;
    logic a_match;
    logic p_match;
    logic a_skip;
    logic ard_origin;
    logic cnt_end_a;
    logic smp_more;
    logic cnt_lt_sh;
    logic draw_done;
    logic emit_ok;
    logic out_free;
    logic pend_v;
  } status_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x_in);
    logic [31:0] x;
    x = x_in;
    x = x ^ (x << XS_A);
    x = x ^ (x >> XS_B);
    x = x ^ (x << XS_C);
    return x;
  endfunction

endpackage

FILE: sv/gmv_ctrl.sv
// ----------------------------------------------------------------------------
// Gossip membership controller
// Sequences every operation as steps on the datapath: draws, view scans,
// adds, removals and message emission.
// ----------------------------------------------------------------------------
module gmv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gmv_pkg::status_t st_i,
  output gmv_pkg::cmd_t    cmd_o
);

  typedef enum logic [35:0] {
    S_IDLE   = (36'd1 << 0),  S_DISP   = (36'd1 << 1),  S_DRAW   = (36'd1 << 2),
    S_DRAW_W = (36'd1 << 3),  S_SCAN   = (36'd1 << 4),  S_SCAN_C = (36'd1 << 5),
    S_ADD    = (36'd1 << 6),  S_ADD_W  = (36'd1 << 7),  S_TAKE   = (36'd1 << 8),
    S_TAKE_W = (36'd1 << 9),  S_J1     = (36'd1 << 10), S_J2     = (36'd1 << 11),
    S_JA     = (36'd1 << 12), S_JB     = (36'd1 << 13), S_J3     = (36'd1 << 14),
    S_J4     = (36'd1 << 15), S_J5     = (36'd1 << 16), S_J6     = (36'd1 << 17),
    S_F1     = (36'd1 << 18), S_F2     = (36'd1 << 19), S_F3     = (36'd1 << 20),
    S_F4     = (36'd1 << 21), S_D1     = (36'd1 << 22), S_D2     = (36'd1 << 23),
    S_D3     = (36'd1 << 24), S_D4     = (36'd1 << 25), S_D5     = (36'd1 << 26),
    S_S1     = (36'd1 << 27), S_S2     = (36'd1 << 28), S_SM0    = (36'd1 << 29),
    S_SM1    = (36'd1 << 30), S_SM2    = (36'd1 << 31), S_SM3    = (36'd1 << 32),
    S_T1     = (36'd1 << 33), S_T2     = (36'd1 << 34), S_FIN    = (36'd1 << 35)
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  state_e sret_q, sret_d;
  gmv_pkg::mem_e msel_q, msel_d;
  logic found_q, found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      sret_q  <= S_IDLE;
      msel_q  <= gmv_pkg::MEM_A;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      sret_q  <= sret_d;
      msel_q  <= msel_d;
      found_q <= found_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    sret_d     = sret_q;
    msel_d     = msel_q;
    found_d    = found_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mem  = msel_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st_i.op)
          gmv_pkg::OP_JOIN: begin
            if (st_i.origin_self) begin
              state_d = S_FIN;
            end else if (st_i.a_full) begin
              msel_d = gmv_pkg::MEM_A;
              ret_d = S_J1;
              state_d = S_DRAW;
            end else begin
              state_d = S_J3;
            end
          end
          gmv_pkg::OP_FWD: begin
            cmd_o.key_sel = gmv_pkg::KEY_ORIGIN;
            if (st_i.origin_self) begin
              state_d = S_FIN;
            end else if (st_i.ttl_zero || st_i.a_le1) begin
              cmd_o.key_ld = 1'b1;
              msel_d = gmv_pkg::MEM_A;
              ret_d = S_FIN;
              state_d = S_ADD;
            end else if (st_i.ttl_pw) begin
              cmd_o.key_ld = 1'b1;
              msel_d = gmv_pkg::MEM_P;
              ret_d = S_F1;
              state_d = S_ADD;
            end else begin
              state_d = S_F1;
            end
          end
          gmv_pkg::OP_DISC: begin
            cmd_o.key_ld = 1'b1;
            cmd_o.key_sel = gmv_pkg::KEY_SENDER;
            cmd_o.idx_op = gmv_pkg::IDX_CLR;
            msel_d = gmv_pkg::MEM_A;
            sret_d = S_D1;
            state_d = S_SCAN;
          end
          gmv_pkg::OP_SHUF: begin
            cmd_o.key_ld = 1'b1;
            cmd_o.key_sel = gmv_pkg::KEY_ENTRY;
            msel_d = gmv_pkg::MEM_P;
            if (st_i.evalid && !st_i.entry_self) begin
              if (st_i.p_full) begin
                ret_d = S_S1;
                state_d = S_DRAW;
              end else begin
                ret_d = S_S2;
                state_d = S_ADD;
              end
            end else begin
              state_d = S_S2;
            end
          end
          gmv_pkg::OP_REPLY: begin
            if (st_i.evalid && !st_i.entry_self && !st_i.p_full) begin
              cmd_o.key_ld = 1'b1;
              cmd_o.key_sel = gmv_pkg::KEY_ENTRY;
              msel_d = gmv_pkg::MEM_P;
              ret_d = S_FIN;
              state_d = S_ADD;
            end else begin
              state_d = S_FIN;
            end
          end
          gmv_pkg::OP_TICK: begin
            if (st_i.period_hit) begin
              cmd_o.lst_ld = 1'b1;
              if (!st_i.a_empty) begin
                msel_d = gmv_pkg::MEM_A;
                ret_d = S_T1;
                state_d = S_DRAW;
              end else begin
                state_d = S_FIN;
              end
            end else begin
              state_d = S_FIN;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_DRAW: begin
        cmd_o.draw_go = 1'b1;
        state_d = S_DRAW_W;
      end
      S_DRAW_W: begin
        if (st_i.draw_done) begin
          cmd_o.idx_op = gmv_pkg::IDX_DRAW;
          state_d = ret_q;
        end
      end
      S_SCAN: begin
        if ((msel_q == gmv_pkg::MEM_A) ? st_i.a_end : st_i.p_end) begin
          found_d = 1'b0;
          state_d = sret_q;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = S_SCAN_C;
        end
      end
      S_SCAN_C: begin
        if ((msel_q == gmv_pkg::MEM_A) ? st_i.a_match : st_i.p_match) begin
          found_d = 1'b1;
          state_d = sret_q;
        end else begin
          cmd_o.idx_op = gmv_pkg::IDX_INC;
          state_d = S_SCAN;
        end
      end
      S_ADD: begin
        if ((msel_q == gmv_pkg::MEM_A) ? st_i.a_full : st_i.p_full) begin
          state_d = ret_q;
        end else begin
          cmd_o.idx_op = gmv_pkg::IDX_CLR;
          sret_d = S_ADD_W;
          state_d = S_SCAN;
        end
      end
      S_ADD_W: begin
        if (!found_q) begin
          cmd_o.wr = 1'b1;
          cmd_o.wr_at_used = 1'b1;
          cmd_o.wr_key = 1'b1;
          cmd_o.use_inc = 1'b1;
        end
        state_d = ret_q;
      end
      S_TAKE: begin
        cmd_o.rd = 1'b1;
        cmd_o.rd_last = 1'b1;
        state_d = S_TAKE_W;
      end
      S_TAKE_W: begin
        cmd_o.wr = 1'b1;
        cmd_o.use_dec = 1'b1;
        state_d = ret_q;
      end
      S_J1: begin
        cmd_o.rd = 1'b1;
        state_d = S_J2;
      end
      S_J2: begin
        cmd_o.tmp_ld = 1'b1;
        ret_d = S_JA;
        state_d = S_TAKE;
      end
      S_JA: begin
        cmd_o.key_ld = 1'b1;
        cmd_o.key_sel = gmv_pkg::KEY_TMP;
        msel_d = gmv_pkg::MEM_P;
        ret_d = S_JB;
        state_d = S_ADD;
      end
      S_JB: begin
        if (st_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_sel = gmv_pkg::EM_DISC;
          state_d = S_J3;
        end
      end
      S_J3: begin
        cmd_o.key_ld = 1'b1;
        cmd_o.key_sel = gmv_pkg::KEY_ORIGIN;
        msel_d = gmv_pkg::MEM_A;
        ret_d = S_J4;
        state_d = S_ADD;
      end
      S_J4: begin
        cmd_o.idx_op = gmv_pkg::IDX_CLR;
        state_d = S_J5;
      end
      S_J5: begin
        if (st_i.a_end) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = S_J6;
        end
      end
      S_J6: begin
        if (st_i.ard_origin) begin
          cmd_o.idx_op = gmv_pkg::IDX_INC;
          state_d = S_J5;
        end else if (st_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_sel = gmv_pkg::EM_FJ6;
          cmd_o.idx_op = gmv_pkg::IDX_INC;
          state_d = S_J5;
        end
      end
      S_F1: begin
        msel_d = gmv_pkg::MEM_A;
        ret_d = S_F2;
        state_d = S_DRAW;
      end
      S_F2: begin
        cmd_o.cnt_op = gmv_pkg::CNT_CLR;
        state_d = S_F3;
      end
      S_F3: begin
        if (st_i.cnt_end_a) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = S_F4;
        end
      end
      S_F4: begin
        if (st_i.a_skip) begin
          cmd_o.idx_op = gmv_pkg::IDX_WRAP;
          cmd_o.cnt_op = gmv_pkg::CNT_INC;
          state_d = S_F3;
        end else if (st_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_sel = gmv_pkg::EM_FJT;
          state_d = S_FIN;
        end
      end
      S_D1: begin
        if (found_q) begin
          ret_d = S_D2;
          state_d = S_TAKE;
        end else begin
          state_d = S_D2;
        end
      end
      S_D2: begin
        if (!st_i.p_empty && !st_i.a_full) begin
          msel_d = gmv_pkg::MEM_P;
          ret_d = S_D3;
          state_d = S_DRAW;
        end else begin
          state_d = S_FIN;
        end
      end
      S_D3: begin
        cmd_o.rd = 1'b1;
        state_d = S_D4;
      end
      S_D4: begin
        cmd_o.tmp_ld = 1'b1;
        ret_d = S_D5;
        state_d = S_TAKE;
      end
      S_D5: begin
        cmd_o.key_ld = 1'b1;
        cmd_o.key_sel = gmv_pkg::KEY_TMP;
        msel_d = gmv_pkg::MEM_A;
        ret_d = S_FIN;
        state_d = S_ADD;
      end
      S_S1: begin
        cmd_o.wr = 1'b1;
        cmd_o.wr_key = 1'b1;
        state_d = S_S2;
      end
      S_S2: begin
        if (st_i.elast) begin
          cmd_o.cnt_op = gmv_pkg::CNT_CLR;
          state_d = S_SM0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SM0: begin
        if (st_i.smp_more) begin
          msel_d = gmv_pkg::MEM_P;
          ret_d = S_SM1;
          state_d = S_DRAW;
        end else if ((st_i.op == gmv_pkg::OP_TICK) && st_i.cnt_lt_sh) begin
          state_d = S_SM3;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SM1: begin
        cmd_o.rd = 1'b1;
        state_d = S_SM2;
      end
      S_SM2: begin
        if (st_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_sel = gmv_pkg::EM_SMP;
          cmd_o.cnt_op = gmv_pkg::CNT_INC;
          state_d = S_SM0;
        end
      end
      S_SM3: begin
        if (st_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_sel = gmv_pkg::EM_SELF;
          state_d = S_FIN;
        end
      end
      S_T1: begin
        cmd_o.rd = 1'b1;
        state_d = S_T2;
      end
      S_T2: begin
        cmd_o.tmp_ld = 1'b1;
        cmd_o.cnt_op = gmv_pkg::CNT_CLR;
        state_d = S_SM0;
      end
      S_FIN: begin
        if (!st_i.pend_v) begin
          state_d = S_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: sv/gmv_dp.sv
// ----------------------------------------------------------------------------
// Gossip membership datapath
// View memories and counters, random draw with serial remainder, item and
// configuration registers, and a pending stage in front of the output.
// ----------------------------------------------------------------------------
`include "gossip_membership_views_macros.svh"

module gmv_dp #(
  parameter int ACTIVE_SIZE  = 5,
  parameter int PASSIVE_SIZE = 30,
  parameter int SHUFFLE_SIZE = 3,
  parameter int ID_BITS      = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gmv_pkg::cmd_t      cmd_i,
  output gmv_pkg::status_t   st_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic [2:0]         operation_i,
  input  logic [ID_BITS-1:0] sender_id_i,
  input  logic [ID_BITS-1:0] origin_id_i,
  input  logic [7:0]         ttl_i,
  input  logic [ID_BITS-1:0] entry_id_i,
  input  logic               entry_valid_i,
  input  logic               last_entry_i,
  input  logic [63:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ID_BITS-1:0] dest_id_o,
  output logic [1:0]         msg_kind_o,
  output logic [7:0]         msg_ttl_o,
  output logic [ID_BITS-1:0] msg_origin_o,
  output logic [ID_BITS-1:0] payload_id_o,
  output logic               payload_valid_o,
  output logic               last_o
);

  localparam int AIW = $clog2(ACTIVE_SIZE);
  localparam int PIW = $clog2(PASSIVE_SIZE);
  localparam int ACW = $clog2(ACTIVE_SIZE + 1);
  localparam int PCW = $clog2(PASSIVE_SIZE + 1);
  localparam int CW  = (ACW > PCW) ? ACW : PCW;
  localparam int SCW = $clog2(SHUFFLE_SIZE + 1);
  localparam int NW  = (CW > SCW) ? CW : SCW;

  logic [ID_BITS-1:0] self_q;
  logic [31:0]        period_q, seed_q;
  logic [2:0]         op_q;
  logic [ID_BITS-1:0] sender_q, origin_q, entry_q;
  logic [7:0]         ttl_q;
  logic               evalid_q, elast_q;
  logic [63:0]        now_q, lst_q;
  logic [ID_BITS-1:0] amem [ACTIVE_SIZE];
  logic [ID_BITS-1:0] pmem [PASSIVE_SIZE];
  logic [ID_BITS-1:0] ard_q, prd_q, key_q, tmp_q, key_d;
  logic [ACW-1:0]     a_used_q;
  logic [PCW-1:0]     p_used_q;
  logic [CW-1:0]      idx_q, idx_nx;
  logic [NW-1:0]      cnt_q;
  logic [31:0]        rng_q, seed_sel, rng_nx, div_q;
  logic [CW-1:0]      rem_q, dn_q;
  logic [CW:0]        rem2;
  logic [5:0]         dcnt_q;
  logic [AIW-1:0]     a_raddr, a_waddr;
  logic [PIW-1:0]     p_raddr, p_waddr;
  logic [ID_BITS-1:0] pd_dest_q, pd_org_q, pd_pay_q;
  logic [1:0]         pd_kind_q;
  logic [7:0]         pd_ttl_q;
  logic               pd_pv_q, pend_v_q, out_v_q, out_ld;
  logic [ID_BITS-1:0] em_dest, em_org, em_pay;
  logic [1:0]         em_kind;
  logic [7:0]         em_ttl;
  logic               em_pv, is_reply;
  logic               a_inc, p_inc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q   <= '0;
      period_q <= gmv_pkg::PERIOD_RESET;
      seed_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gmv_pkg::CFG_SELF:   self_q   <= cfg_data_i[ID_BITS-1:0];
        gmv_pkg::CFG_PERIOD: period_q <= cfg_data_i[31:0];
        gmv_pkg::CFG_SEED:   seed_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= operation_i;
      sender_q <= sender_id_i;
      origin_q <= origin_id_i;
      ttl_q    <= ttl_i;
      entry_q  <= entry_id_i;
      evalid_q <= entry_valid_i;
      elast_q  <= last_entry_i;
      now_q    <= now_ms_i;
    end
  end

  always_comb begin
    case (cmd_i.key_sel)
      gmv_pkg::KEY_ORIGIN: key_d = origin_q;
      gmv_pkg::KEY_ENTRY:  key_d = entry_q;
      gmv_pkg::KEY_SENDER: key_d = sender_q;
      default:             key_d = tmp_q;
    endcase
  end

  assign a_raddr = cmd_i.rd_last ? AIW'(a_used_q - ACW'(1)) : idx_q[AIW-1:0];
  assign p_raddr = cmd_i.rd_last ? PIW'(p_used_q - PCW'(1)) : idx_q[PIW-1:0];
  assign a_waddr = cmd_i.wr_at_used ? AIW'(a_used_q) : idx_q[AIW-1:0];
  assign p_waddr = cmd_i.wr_at_used ? PIW'(p_used_q) : idx_q[PIW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd && cmd_i.mem == gmv_pkg::MEM_A) begin
      ard_q <= amem[a_raddr];
    end
    if (cmd_i.rd && cmd_i.mem == gmv_pkg::MEM_P) begin
      prd_q <= pmem[p_raddr];
    end
    if (cmd_i.wr && cmd_i.mem == gmv_pkg::MEM_A) begin
      amem[a_waddr] <= cmd_i.wr_key ? key_q : ard_q;
    end
    if (cmd_i.wr && cmd_i.mem == gmv_pkg::MEM_P) begin
      pmem[p_waddr] <= cmd_i.wr_key ? key_q : prd_q;
    end
    if (cmd_i.key_ld) begin
      key_q <= key_d;
    end
    if (cmd_i.tmp_ld) begin
      tmp_q <= (cmd_i.mem == gmv_pkg::MEM_A) ? ard_q : prd_q;
    end
  end

  assign idx_nx = idx_q + CW'(1);

  always_ff @(posedge clk_i) begin
    case (cmd_i.idx_op)
      gmv_pkg::IDX_CLR:  idx_q <= '0;
      gmv_pkg::IDX_INC:  idx_q <= idx_nx;
      gmv_pkg::IDX_WRAP: idx_q <= (idx_nx == CW'(a_used_q)) ? '0 : idx_nx;
      gmv_pkg::IDX_DRAW: idx_q <= rem_q;
      default: ;
    endcase
    case (cmd_i.cnt_op)
      gmv_pkg::CNT_CLR: cnt_q <= '0;
      gmv_pkg::CNT_INC: cnt_q <= cnt_q + NW'(1);
      default: ;
    endcase
  end

  assign a_inc = cmd_i.use_inc && (cmd_i.mem == gmv_pkg::MEM_A);
  assign p_inc = cmd_i.use_inc && (cmd_i.mem == gmv_pkg::MEM_P);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_used_q <= '0;
      p_used_q <= '0;
      lst_q    <= '0;
    end else begin
      if (a_inc) a_used_q <= a_used_q + ACW'(1);
      else if (cmd_i.use_dec && cmd_i.mem == gmv_pkg::MEM_A) a_used_q <= a_used_q - ACW'(1);
      if (p_inc) p_used_q <= p_used_q + PCW'(1);
      else if (cmd_i.use_dec && cmd_i.mem == gmv_pkg::MEM_P) p_used_q <= p_used_q - PCW'(1);
      if (cmd_i.lst_ld) lst_q <= now_q;
    end
  end

  // Draw: one xorshift step, then a restoring remainder one bit per cycle.
  assign seed_sel = (rng_q != '0) ? rng_q :
                    ((seed_q == '0) ? gmv_pkg::SEED_FALLBACK : seed_q);
  assign rng_nx   = gmv_pkg::xorshift32(seed_sel);
  assign rem2     = {rem_q, div_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.draw_go) begin
      rng_q  <= rng_nx;
      dcnt_q <= 6'd32;
    end else if (dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_go) begin
      div_q <= rng_nx;
      rem_q <= '0;
      dn_q  <= (cmd_i.mem == gmv_pkg::MEM_A) ? CW'(a_used_q) : CW'(p_used_q);
    end else if (dcnt_q != '0) begin
      div_q <= div_q << 1;
      rem_q <= (rem2 >= {1'b0, dn_q}) ? CW'(rem2 - {1'b0, dn_q}) : rem2[CW-1:0];
    end
  end

  assign is_reply = (op_q == gmv_pkg::OP_SHUF);

  always_comb begin
    em_dest = ard_q;
    em_kind = gmv_pkg::MK_FJ;
    em_ttl  = gmv_pkg::ACTIVE_WALK;
    em_org  = origin_q;
    em_pay  = '0;
    em_pv   = 1'b0;
    case (cmd_i.emit_sel)
      gmv_pkg::EM_DISC: begin
        em_dest = tmp_q;
        em_kind = gmv_pkg::MK_DISC;
        em_ttl  = '0;
        em_org  = '0;
      end
      gmv_pkg::EM_FJ6: ;
      gmv_pkg::EM_FJT: em_ttl = ttl_q - 8'd1;
      default: begin
        em_dest = is_reply ? sender_q : tmp_q;
        em_kind = is_reply ? gmv_pkg::MK_REPLY : gmv_pkg::MK_SHUF;
        em_ttl  = is_reply ? 8'd0 : gmv_pkg::ACTIVE_WALK;
        em_org  = self_q;
        em_pay  = (cmd_i.emit_sel == gmv_pkg::EM_SMP) ? prd_q : self_q;
        em_pv   = 1'b1;
      end
    endcase
  end

  // The newest message waits in the pending stage until the next one or the
  // end of the item shows whether it is the last one.
  assign out_ld = (cmd_i.emit && pend_v_q) || cmd_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (out_ld) out_v_q <= 1'b1;
      else if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (cmd_i.flush) pend_v_q <= 1'b0;
      else if (cmd_i.emit) pend_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      dest_id_o       <= pd_dest_q;
      msg_kind_o      <= pd_kind_q;
      msg_ttl_o       <= pd_ttl_q;
      msg_origin_o    <= pd_org_q;
      payload_id_o    <= pd_pay_q;
      payload_valid_o <= pd_pv_q;
      last_o          <= cmd_i.flush;
    end
    if (cmd_i.emit) begin
      pd_dest_q <= em_dest;
      pd_kind_q <= em_kind;
      pd_ttl_q  <= em_ttl;
      pd_org_q  <= em_org;
      pd_pay_q  <= em_pay;
      pd_pv_q   <= em_pv;
    end
  end

  assign out_valid_o = out_v_q;

  always_comb begin
    st_o.op          = op_q;
    st_o.origin_self = (origin_q == self_q);
    st_o.entry_self  = (entry_q == self_q);
    st_o.evalid      = evalid_q;
    st_o.elast       = elast_q;
    st_o.ttl_zero    = (ttl_q == 8'd0);
    st_o.ttl_pw      = (ttl_q == gmv_pkg::PASSIVE_WALK);
    st_o.a_full      = (a_used_q >= ACW'(ACTIVE_SIZE));
    st_o.a_le1       = (a_used_q <= ACW'(1));
    st_o.a_empty     = (a_used_q == '0);
    st_o.p_empty     = (p_used_q == '0);
    st_o.p_full      = (p_used_q >= PCW'(PASSIVE_SIZE));
    st_o.period_hit  = ((now_q - lst_q) >= {32'd0, period_q});
    st_o.a_end       = (idx_q >= CW'(a_used_q));
    st_o.p_end       = (idx_q >= CW'(p_used_q));
    st_o.a_match     = (ard_q == key_q);
    st_o.p_match     = (prd_q == key_q);
    st_o.a_skip      = (ard_q == origin_q) || (ard_q == self_q);
    st_o.ard_origin  = (ard_q == origin_q);
    st_o.cnt_end_a   = (cnt_q >= NW'(a_used_q));
    st_o.smp_more    = (cnt_q < NW'(SHUFFLE_SIZE)) && (cnt_q < NW'(p_used_q));
    st_o.cnt_lt_sh   = (cnt_q < NW'(SHUFFLE_SIZE));
    st_o.draw_done   = (dcnt_q == '0);
    st_o.emit_ok     = !pend_v_q || !out_v_q;
    st_o.out_free    = !out_v_q;
    st_o.pend_v      = pend_v_q;
  end

  `GMV_ASSERT(a_room_a, a_inc |-> (a_used_q < ACW'(ACTIVE_SIZE)), "active view overflow")
  `GMV_ASSERT(p_room_a, p_inc |-> (p_used_q < PCW'(PASSIVE_SIZE)), "passive view overflow")
  `GMV_ASSERT(emit_room_a, cmd_i.emit |-> (!pend_v_q || !out_v_q), "message emitted with no room")
  `GMV_ASSERT_NEXT(flush_a, cmd_i.flush, (!pend_v_q && out_v_q && last_o), "flush did not end the item")

endmodule

FILE: sv/gossip_membership_views.sv
// ----------------------------------------------------------------------------
// Gossip membership views
// Active and passive peer views with join, forward-join, disconnect and
// shuffle handling; emits the outgoing protocol messages of each item.
// ----------------------------------------------------------------------------
// One item is handled at a time. Random draws go through the bit-serial
// remainder unit, and each view search or insert visits the stored entries
// one at a time through the single registered read port of the view
// memories. Results leave through an output register with one pending
// stage behind it, so the last flag is set on the final message of each
// item; a stalled output holds up the item.
module gossip_membership_views #(
  parameter int ACTIVE_SIZE  = 5,
  parameter int PASSIVE_SIZE = 30,
  parameter int SHUFFLE_SIZE = 3,
  parameter int ID_BITS      = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic [ID_BITS-1:0] sender_id_i,
  input  logic [ID_BITS-1:0] origin_id_i,
  input  logic [7:0]         ttl_i,
  input  logic [ID_BITS-1:0] entry_id_i,
  input  logic               entry_valid_i,
  input  logic               last_entry_i,
  input  logic [63:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ID_BITS-1:0] dest_id_o,
  output logic [1:0]         msg_kind_o,
  output logic [7:0]         msg_ttl_o,
  output logic [ID_BITS-1:0] msg_origin_o,
  output logic [ID_BITS-1:0] payload_id_o,
  output logic               payload_valid_o,
  output logic               last_o
);

  gmv_pkg::cmd_t    cmd;
  gmv_pkg::status_t st;

  gmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  gmv_dp #(
    .ACTIVE_SIZE  (ACTIVE_SIZE),
    .PASSIVE_SIZE (PASSIVE_SIZE),
    .SHUFFLE_SIZE (SHUFFLE_SIZE),
    .ID_BITS      (ID_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .sender_id_i     (sender_id_i),
    .origin_id_i     (origin_id_i),
    .ttl_i           (ttl_i),
    .entry_id_i      (entry_id_i),
    .entry_valid_i   (entry_valid_i),
    .last_entry_i    (last_entry_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dest_id_o       (dest_id_o),
    .msg_kind_o      (msg_kind_o),
    .msg_ttl_o       (msg_ttl_o),
    .msg_origin_o    (msg_origin_o),
    .payload_id_o    (payload_id_o),
    .payload_valid_o (payload_valid_o),
    .last_o          (last_o)
  );

endmodule
